// ===== rtl/core/dlps_pkg.sv =====
// Package for the delay line pitch shifter: constants, state type and helpers.
// Used by delay_line_pitch_shifter and dlps_checker; depends on nothing.
package dlps_pkg;

   localparam int STORE_DEPTH_DEF  = 16384;
   localparam int PERIOD_LIMIT_DEF = 9990;
   localparam int SAMPLE_BITS_DEF  = 24;
   localparam int RATIO_BITS       = 19;
   localparam int GAIN_BITS        = 17;
   localparam int PERIOD_BITS      = 14;
   localparam int CFG_DATA_BITS    = 19;
   localparam int CFG_IDX_BITS     = 3;
   localparam logic [16:0] UNITY   = 17'd65536;

   localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_RATIO   = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_LOOP_PERIOD   = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_TRIM_GAIN     = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_WET_MIX       = 3'd4;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_FB, ST_FBDIV, ST_NORM, ST_WRITE, ST_ADV, ST_READ0,
      ST_READ1, ST_READC, ST_INTERP, ST_SPLICE, ST_MIX, ST_TRIM, ST_OUT
   } state_type;

   function automatic logic [16:0] gain_sat(input logic [16:0] g);
      gain_sat = (g > UNITY) ? UNITY : g;
   endfunction

endpackage

// ===== rtl/core/dlps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module dlps_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/delay_line_pitch_shifter.sv =====
// Top level of the delay line pitch shifter: sequencer, datapath and loop store.
// Depends on dlps_pkg and dlps_ram.
//
//  channel | role   | beat content
//  req_    | input  | tdata[SB-1:0] sample_in
//  rsp_    | output | tdata[SB+1:0] sample_out
//  csr_    | config | index, data; write when csr_wr_en
//
// After reset the store is cleared one entry a cycle, with req_tready low.
// Each accepted beat then runs through the sequencer states feedback, write, advance, three
// store reads, interpolate, splice, mix, trim and output around the single store port; when
// the previous mixed loop value exceeded full scale a bit-serial feedback divide is added.
// A result waits in the output register and req_tready stays low until it has been taken.
module delay_line_pitch_shifter
   import dlps_pkg::*;
#(
   parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
   parameter int PERIOD_LIMIT = PERIOD_LIMIT_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,   // sample_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+9)/8)*8-1:0]    rsp_tdata,   // sample_out
   input  logic                                csr_wr_en,
   input  logic [CFG_IDX_BITS-1:0]             csr_index,
   input  logic [CFG_DATA_BITS-1:0]            csr_data
);
   localparam int WB = SAMPLE_BITS + 2;
   localparam int AB = $clog2(STORE_DEPTH);
   localparam int PB = AB + 16;
   localparam int WMAXI = (PERIOD_LIMIT < STORE_DEPTH - 2) ? PERIOD_LIMIT : STORE_DEPTH - 2;
   localparam int IB = (PERIOD_BITS > AB ? PERIOD_BITS : AB) + 1;
   localparam int XB = WB + 18;   // product width
   localparam logic signed [XB-1:0] HI = XB'((64'sd1 <<< (WB-1)) - 1);
   localparam logic signed [XB-1:0] LO = -XB'(64'sd1 <<< (WB-1));
   localparam logic [WB-1:0] FS = WB'(64'd1 << (SAMPLE_BITS-1));
   localparam int DB = WB + SAMPLE_BITS;   // dividend width
   localparam int CB = $clog2(DB);

   logic [RATIO_BITS-1:0]  ratio_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [GAIN_BITS-1:0]   fb_ff, trim_ff, wet_ff;

   state_type state_ff, state_in;
   logic [AB:0] clr_ff;
   logic [IB-1:0] widx_ff;
   logic [PB:0] rpos_ff;
   logic wrap_ff;
   logic [16:0] splice_ff;
   logic signed [WB-1:0] last_ff;
   logic signed [SAMPLE_BITS-1:0] dry_ff;
   logic signed [XB-1:0] acc_ff, acc_in;
   logic signed [WB-1:0] e0_ff, e1_ff, cur_ff;
   logic [DB-1:0] rem_ff, quo_ff;
   logic [CB-1:0] cnt_ff;
   logic sign_ff;
   logic rsp_valid_ff;
   logic [WB-1:0] rsp_ff;

   logic ram_we;
   logic [AB-1:0] ram_wa, ram_ra;
   logic [WB-1:0] ram_wd, ram_rd;

   dlps_ram #(.WIDTH(WB), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd));

   function automatic logic signed [XB-1:0] fl16(input logic signed [XB+17:0] x);
      fl16 = XB'(x >>> 16);
   endfunction
   function automatic logic signed [WB-1:0] satw(input logic signed [XB-1:0] x);
      satw = (x > HI) ? HI[WB-1:0] : (x < LO) ? LO[WB-1:0] : x[WB-1:0];
   endfunction

   logic [IB-1:0] w;
   always_comb begin
      if (period_ff > PERIOD_BITS'(WMAXI)) w = IB'(WMAXI);
      else if (period_ff < PERIOD_BITS'(2)) w = IB'(2);
      else w = IB'(period_ff);
   end

   logic [IB-1:0] cnt_r, i0, i1;
   logic [15:0] frac;
   assign cnt_r = IB'(rpos_ff >> 16);
   assign frac = rpos_ff[15:0];
   assign i0 = (cnt_r > w) ? cnt_r - w - IB'(1) : cnt_r;
   assign i1 = (cnt_r + IB'(1) > w) ? cnt_r - w : cnt_r + IB'(1);

   logic [WB-1:0] lmag;
   assign lmag = last_ff[WB-1] ? WB'(-last_ff) : last_ff;
   logic [DB:0] trial;
   assign trial = {rem_ff[DB-1:0], quo_ff[DB-1]} - (DB+1)'(lmag);

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = $bits(rsp_tdata)'(rsp_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == (AB+1)'(STORE_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid && req_tready) state_in = ST_FB;
         ST_FB:     state_in = (lmag > FS) ? ST_FBDIV : ST_WRITE;
         ST_FBDIV:  if (cnt_ff == CB'(DB - 1)) state_in = ST_NORM;
         ST_NORM:   state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_ADV;
         ST_ADV:    state_in = ST_READ0;
         ST_READ0:  state_in = ST_READ1;
         ST_READ1:  state_in = ST_READC;
         ST_READC:  state_in = ST_INTERP;
         ST_INTERP: state_in = ST_SPLICE;
         ST_SPLICE: state_in = ST_MIX;
         ST_MIX:    state_in = ST_TRIM;
         ST_TRIM:   state_in = ST_OUT;
         ST_OUT:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ram_we = 1'b0;
      ram_wa = widx_ff[AB-1:0];
      ram_wd = satw(acc_ff);
      ram_ra = i0[AB-1:0];
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff[AB-1:0];
            ram_wd = '0;
         end
         ST_WRITE: ram_we = (widx_ff < IB'(STORE_DEPTH));
         ST_READ0: ram_ra = i0[AB-1:0];
         ST_READ1: ram_ra = i1[AB-1:0];
         ST_READC: ram_ra = widx_ff[AB-1:0];
         default: ram_we = 1'b0;
      endcase
   end

   logic [IB-1:0] wn;
   logic [PB:0] rn;
   logic arm, wrap_set;
   logic [XB-1:0] diff;
   logic signed [XB-1:0] dtmp;
   assign dtmp = XB'(acc_ff) - XB'(cur_ff);
   assign diff = dtmp[XB-1] ? -dtmp : dtmp;

   always_comb begin
      wn = widx_ff + IB'(1);
      rn = rpos_ff + (PB+1)'(ratio_ff);
      arm = (rn > ((PB+1)'(wn) << 16)) && wrap_ff;
      wrap_set = 1'b0;
      if (wn > w) begin
         wn = wn - w;
         if (wn > w) wn = IB'(1);
      end
      if (rn > ((PB+1)'(w) << 16)) begin
         rn = rn - ((PB+1)'(w) << 16);
         wrap_set = 1'b1;
         if (rn > ((PB+1)'(w) << 16)) rn = (PB+1)'(w) << 16;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      case (state_ff)
         ST_FB: acc_in = XB'(dry_ff) + fl16((XB+18)'(last_ff) * $signed({1'b0, gain_sat(fb_ff)}));
         ST_NORM: acc_in = sign_ff ? -XB'(quo_ff) : XB'(quo_ff);
         ST_INTERP: acc_in = fl16((XB+18)'(e0_ff) * $signed({1'b0, UNITY - 17'(frac)})
                             + (XB+18)'(e1_ff) * $signed({1'b0, 17'(frac)}));
         ST_MIX: acc_in = XB'(satw(fl16((XB+18)'(cur_ff) * $signed({1'b0, splice_ff})
                             + (XB+18)'(acc_ff) * $signed({1'b0, UNITY - splice_ff}))));
         ST_TRIM: acc_in = fl16((XB+18)'(acc_ff) * $signed({1'b0, gain_sat(trim_ff)}));
         ST_OUT: acc_in = fl16((XB+18)'(acc_ff) * $signed({1'b0, gain_sat(wet_ff)})
                             + (XB+18)'(dry_ff) * $signed({1'b0, UNITY - gain_sat(wet_ff)}));
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; widx_ff <= IB'(1);
         rpos_ff <= (PB+1)'(65536); wrap_ff <= 1'b0; splice_ff <= '0; last_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ratio_ff <= RATIO_BITS'(65536); period_ff <= PERIOD_BITS'(168);
         fb_ff <= '0; trim_ff <= UNITY; wet_ff <= UNITY;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + (AB+1)'(1);
         if (csr_wr_en) begin
            case (csr_index)
               REG_PITCH_RATIO:   ratio_ff  <= csr_data[RATIO_BITS-1:0];
               REG_LOOP_PERIOD:   period_ff <= csr_data[PERIOD_BITS-1:0];
               REG_FEEDBACK_GAIN: fb_ff     <= csr_data[GAIN_BITS-1:0];
               REG_TRIM_GAIN:     trim_ff   <= csr_data[GAIN_BITS-1:0];
               REG_WET_MIX:       wet_ff    <= csr_data[GAIN_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) dry_ff <= req_tdata[SAMPLE_BITS-1:0];
            ST_FB: begin
               // dividend |sum| * FS, quotient built bit by bit
               sign_ff <= acc_in[XB-1];
               quo_ff <= DB'(acc_in[XB-1] ? -acc_in : acc_in) << (SAMPLE_BITS-1);
               rem_ff <= '0;
               cnt_ff <= '0;
            end
            ST_FBDIV: begin
               cnt_ff <= cnt_ff + CB'(1);
               if (!trial[DB]) begin
                  rem_ff <= trial[DB-1:0];
                  quo_ff <= {quo_ff[DB-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[DB-2:0], quo_ff[DB-1]};
                  quo_ff <= {quo_ff[DB-2:0], 1'b0};
               end
            end
            ST_ADV: begin
               if (arm) splice_ff <= UNITY;
               if (arm || wrap_set) wrap_ff <= wrap_set;
               widx_ff <= wn; rpos_ff <= rn;
            end
            ST_READ1: e0_ff <= (i0 < IB'(STORE_DEPTH)) ? ram_rd : '0;
            ST_READC: e1_ff <= (i1 < IB'(STORE_DEPTH)) ? ram_rd : '0;
            ST_INTERP: cur_ff <= (widx_ff < IB'(STORE_DEPTH)) ? ram_rd : '0;
            ST_SPLICE:
               if (((XB+18)'(splice_ff) << (SAMPLE_BITS-1)) > ((XB+18)'(diff) << 17))
                  splice_ff <= 17'((splice_ff >> 1) + 17'((diff << 16) >> (SAMPLE_BITS-1)));
            ST_MIX: last_ff <= acc_in[WB-1:0];
            ST_OUT: begin
               rsp_ff <= satw(acc_in);
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/core/dlps_checker.sv =====
// Port-level checker for the delay line pitch shifter, bound to the top level.
// Depends on dlps_pkg and delay_line_pitch_shifter.
module dlps_checker
   import dlps_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready
);
   a_no_ready_in_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input ready straight after reset");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped");
   a_no_take_while_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while result pending");
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("block not busy after a beat");
endmodule

bind delay_line_pitch_shifter dlps_checker u_dlps_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready));
